>>> rtl/core/filename_sanitizer_stream_unit_defines.svh
// Assertion macros shared by the filename sanitizer checker.
`ifndef FILENAME_SANITIZER_STREAM_UNIT_DEFINES_SVH
`define FILENAME_SANITIZER_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/fss_pkg.sv
// Types, constants and byte classification for the filename sanitizer.
package fss_pkg;

  localparam int unsigned ExtMaxDef = 32;
  localparam int unsigned CmdDepth  = 4;
  // Segment counts hold up to the largest supported extension length (63).
  localparam int unsigned CntW      = 6;

  localparam logic [7:0] ChrUnder   = 8'h5F;
  localparam logic [7:0] ChrSpace   = 8'h20;
  localparam logic [7:0] ChrDash    = 8'h2D;
  localparam logic [7:0] ChrDot     = 8'h2E;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef struct packed {
    logic [7:0] char_in;
    logic       keep_extension;
    logic       last_in;
  } fss_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       run_end;
    logic       name_end;
    logic       ext_overflow;
  } fss_out_t;

  // One command per input byte that has work for the back end.
  typedef struct packed {
    logic [7:0]      ch;
    logic            flush;      // sanitize buffered segment first
    logic            san;        // sanitize ch
    logic            raw;        // emit '.' and buffer raw
    logic            last;
    logic            ovf;
    logic [CntW-1:0] flush_cnt;
    logic [CntW-1:0] raw_cnt;
  } fss_cmd_t;

  typedef struct packed {
    logic       keep;
    logic       sep;
    logic [7:0] folded;
  } fss_cls_t;

  function automatic fss_cls_t fss_classify(logic [7:0] c);
    fss_cls_t r;
    logic     upper;
    upper    = (c >= 8'h41) && (c <= 8'h5A);
    r.keep   = upper || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h30) && (c <= 8'h39));
    r.sep    = (c == ChrUnder) || (c == ChrSpace) || (c == ChrDash) || (c == ChrDot);
    r.folded = upper ? c + CaseOffset : c;
    return r;
  endfunction

endpackage

>>> rtl/core/fss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fss_cmd_fifo.sv
// Small command queue between the classifier and the emitter.
module fss_cmd_fifo #(
  parameter int unsigned Depth = fss_pkg::CmdDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fss_pkg::fss_cmd_t data_i,
  input  logic             pop_i,
  output fss_pkg::fss_cmd_t data_o,
  output logic             empty_o,
  output logic             full_o
);
  import fss_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntFW = $clog2(Depth + 1);

  fss_cmd_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntFW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFW'(Depth));
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntFW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntFW'(1);
      end
    end
  end

endmodule

>>> rtl/core/fss_front.sv
// Front end: accepts input bytes, tracks the extension segment, buffers it, queues commands.
module fss_front #(
  parameter int unsigned ExtMax = fss_pkg::ExtMaxDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  fss_pkg::fss_in_t          in_data_i,
  output logic                      push_o,
  output fss_pkg::fss_cmd_t         cmd_o,
  input  logic                      fifo_full_i,
  output logic                      wr_en_o,
  output logic [$clog2(ExtMax)-1:0] wr_addr_o,
  output logic [7:0]                wr_data_o,
  input  logic                      rd_done_i
);
  import fss_pkg::*;

  localparam int unsigned AddrW = $clog2(ExtMax);

  logic            start_q, keep_q, seg_q, ovf_q, rd_pend_q;
  logic [CntW-1:0] cnt_q;

  logic            acc, keep_eff, seg, ovf, seg_n, ovf_n, is_dot, wr_req;
  logic [CntW-1:0] cnt, cnt_n;
  fss_cmd_t        cmd;

  // A queued command that reads the buffer blocks input until it is done.
  assign in_ready_o = !rd_pend_q && !fifo_full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    keep_eff = start_q ? in_data_i.keep_extension : keep_q;
    seg      = start_q ? 1'b0 : seg_q;
    cnt      = start_q ? '0 : cnt_q;
    ovf      = start_q ? 1'b0 : ovf_q;
    is_dot   = (in_data_i.char_in == ChrDot);
    seg_n    = seg;
    cnt_n    = cnt;
    ovf_n    = ovf;
    wr_req   = 1'b0;

    cmd           = '0;
    cmd.ch        = in_data_i.char_in;
    cmd.last      = in_data_i.last_in;
    cmd.flush_cnt = cnt;

    if (seg) begin
      if (is_dot) begin
        cmd.flush = 1'b1;
        cnt_n     = '0;
      end else if (cnt >= CntW'(ExtMax)) begin
        // segment too long: the dot becomes a separator
        ovf_n     = 1'b1;
        cmd.flush = 1'b1;
        cmd.san   = 1'b1;
        seg_n     = 1'b0;
        cnt_n     = '0;
      end else begin
        wr_req = 1'b1;
        cnt_n  = cnt + CntW'(1);
      end
    end else if (keep_eff && is_dot) begin
      seg_n = 1'b1;
      cnt_n = '0;
    end else begin
      cmd.san = 1'b1;
    end

    cmd.ovf = ovf_n;

    if (in_data_i.last_in) begin
      cmd.raw     = seg_n;
      cmd.raw_cnt = cnt_n;
      seg_n       = 1'b0;
      cnt_n       = '0;
    end
  end

  assign cmd_o     = cmd;
  assign push_o    = acc && (cmd.flush || cmd.san || cmd.last);
  assign wr_en_o   = acc && wr_req;
  assign wr_addr_o = cnt[AddrW-1:0];
  assign wr_data_o = in_data_i.char_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 1'b1;
      keep_q    <= 1'b0;
      seg_q     <= 1'b0;
      ovf_q     <= 1'b0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (acc) begin
        start_q <= in_data_i.last_in;
        keep_q  <= keep_eff;
        seg_q   <= seg_n;
        ovf_q   <= ovf_n;
        cnt_q   <= cnt_n;
      end
      if (push_o && (cmd.flush || cmd.raw)) begin
        rd_pend_q <= 1'b1;
      end else if (rd_done_i) begin
        rd_pend_q <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/fss_back.sv
// Back end: runs queued commands, sanitizes or copies bytes, drives the result register.
module fss_back #(
  parameter int unsigned ExtMax = fss_pkg::ExtMaxDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fss_pkg::fss_cmd_t         cmd_i,
  input  logic                      cmd_valid_i,
  output logic                      pop_o,
  output logic [$clog2(ExtMax)-1:0] rd_addr_o,
  input  logic [7:0]                rd_data_i,
  output logic                      rd_done_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output fss_pkg::fss_out_t         out_data_o
);
  import fss_pkg::*;

  localparam int unsigned AddrW = $clog2(ExtMax);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BYTE  = 6'b000010,
    S_FETCH = 6'b000100,
    S_PROC  = 6'b001000,
    S_DOT   = 6'b010000,
    S_END   = 6'b100000
  } fss_state_e;

  fss_state_e      state_q, state_d;
  fss_cmd_t        cmd_q, cmd_d;
  logic [CntW-1:0] idx_q, idx_d, idx_inc;
  logic            raw_mode_q, raw_mode_d;
  logic            sep_done_q, sep_done_d;
  logic            emitted_q, emitted_d;
  logic            pend_q, pend_d;
  logic            hold_v_q, hold_v_d;
  logic [7:0]      hold_ch_q, hold_ch_d;
  logic            out_valid_q, out_valid_d;
  fss_out_t        out_q, out_d;

  logic            out_free, prod, san_sep;
  logic [7:0]      prod_ch, san_src;
  fss_cls_t        cls;

  function automatic fss_state_e after_flush(fss_cmd_t c);
    if (c.san) begin
      return S_BYTE;
    end else if (c.raw) begin
      return S_DOT;
    end
    return S_END;
  endfunction

  assign out_free  = !out_valid_q || out_ready_i;
  assign rd_addr_o = idx_q[AddrW-1:0];
  assign idx_inc   = idx_q + CntW'(1);
  assign san_src   = (state_q == S_BYTE) ? cmd_q.ch : rd_data_i;
  assign cls       = fss_classify(san_src);
  // separator goes out first, then the kept character
  assign san_sep   = cls.keep && pend_q && emitted_q && !sep_done_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    raw_mode_d  = raw_mode_q;
    sep_done_d  = sep_done_q;
    emitted_d   = emitted_q;
    pend_d      = pend_q;
    hold_v_d    = hold_v_q;
    hold_ch_d   = hold_ch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    rd_done_o   = 1'b0;
    prod        = 1'b0;
    prod_ch     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o      = 1'b1;
          cmd_d      = cmd_i;
          idx_d      = '0;
          raw_mode_d = 1'b0;
          sep_done_d = 1'b0;
          if (cmd_i.flush) begin
            pend_d = 1'b1;
          end
          state_d = (cmd_i.flush && cmd_i.flush_cnt != '0) ? S_FETCH : after_flush(cmd_i);
        end
      end
      S_BYTE, S_PROC: begin
        if (out_free) begin
          if (state_q == S_PROC && raw_mode_q) begin
            prod    = 1'b1;
            prod_ch = rd_data_i;
            idx_d   = idx_inc;
            state_d = (idx_inc == cmd_q.raw_cnt) ? S_END : S_FETCH;
          end else begin
            prod    = cls.keep;
            prod_ch = san_sep ? ChrUnder : cls.folded;
            if (san_sep) begin
              sep_done_d = 1'b1;
            end else begin
              sep_done_d = 1'b0;
              if (cls.keep) begin
                emitted_d = 1'b1;
                pend_d    = 1'b0;
              end else if (cls.sep) begin
                pend_d = 1'b1;
              end
              if (state_q == S_BYTE) begin
                state_d = S_END;
              end else begin
                idx_d   = idx_inc;
                state_d = (idx_inc == cmd_q.flush_cnt) ? after_flush(cmd_q) : S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_PROC;
      end
      S_DOT: begin
        if (out_free) begin
          prod       = 1'b1;
          prod_ch    = ChrDot;
          idx_d      = '0;
          raw_mode_d = 1'b1;
          state_d    = (cmd_q.raw_cnt != '0) ? S_FETCH : S_END;
        end
      end
      S_END: begin
        if (out_free) begin
          if (hold_v_q) begin
            out_valid_d = 1'b1;
            out_d       = '{char_out: hold_ch_q, char_valid: 1'b1, run_end: 1'b1,
                            name_end: cmd_q.last, ext_overflow: cmd_q.ovf};
            hold_v_d    = 1'b0;
          end else if (cmd_q.last) begin
            out_valid_d = 1'b1;
            out_d       = '{char_out: 8'h00, char_valid: 1'b0, run_end: 1'b1,
                            name_end: 1'b1, ext_overflow: cmd_q.ovf};
          end
          if (cmd_q.last) begin
            emitted_d = 1'b0;
            pend_d    = 1'b0;
          end
          rd_done_o = cmd_q.flush || cmd_q.raw;
          state_d   = S_IDLE;
          if (cmd_valid_i) begin
            pop_o      = 1'b1;
            cmd_d      = cmd_i;
            idx_d      = '0;
            raw_mode_d = 1'b0;
            sep_done_d = 1'b0;
            if (cmd_i.flush) begin
              pend_d = 1'b1;
            end
            state_d = (cmd_i.flush && cmd_i.flush_cnt != '0) ? S_FETCH : after_flush(cmd_i);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one result is held back so the last one of a byte can carry run_end
    if (prod) begin
      if (hold_v_q) begin
        out_valid_d = 1'b1;
        out_d       = '{char_out: hold_ch_q, char_valid: 1'b1, run_end: 1'b0,
                        name_end: 1'b0, ext_overflow: cmd_q.ovf};
      end
      hold_v_d  = 1'b1;
      hold_ch_d = prod_ch;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    hold_ch_q <= hold_ch_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      raw_mode_q  <= 1'b0;
      sep_done_q  <= 1'b0;
      emitted_q   <= 1'b0;
      pend_q      <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      raw_mode_q  <= raw_mode_d;
      sep_done_q  <= sep_done_d;
      emitted_q   <= emitted_d;
      pend_q      <= pend_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/filename_sanitizer_stream_unit.sv
// Top level of the streaming file-name sanitizer.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one raw byte of a name per
// transfer, last_in on the final byte; keep_extension is sampled on the first byte.
// Output channel (out_valid_o / out_ready_i / out_data_o): one sanitized byte per
// transfer; run_end closes the results of one input byte, name_end closes the name,
// and an empty name yields a single transfer with char_valid low.
// The emitter takes a plain byte through its byte state, with an extra step when a
// separator goes out ahead of it. It walks the segment buffer one entry at a time
// through a fetch and a process state, so a dot flush or the raw extension at name
// end is paced by the single RAM read port.
// While such a buffer walk is queued or running the input is held off.
// The first result of a byte waits behind any queued work, and one result is held
// back so that the last one of a byte can carry run_end.
// A 4-entry command queue decouples intake from emission, so input keeps flowing
// while the output is stalled until the queue fills; a stalled result holds steady.
// Reset: asynchronous, active low; clears all control state, the next byte
// starts a new name. The segment RAM needs no clearing.
module filename_sanitizer_stream_unit #(
  parameter int unsigned ExtMax = fss_pkg::ExtMaxDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fss_pkg::fss_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fss_pkg::fss_out_t out_data_o
);
  import fss_pkg::*;

  localparam int unsigned AddrW = $clog2(ExtMax);

  logic             push, pop, fifo_empty, fifo_full, rd_done, wr_en;
  fss_cmd_t         cmd_in, cmd_head;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;

  // Front: classify bytes, buffer the extension segment, queue work.
  fss_front #(.ExtMax(ExtMax)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .cmd_o       (cmd_in),
    .fifo_full_i (fifo_full),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_done_i   (rd_done)
  );

  fss_cmd_fifo #(.Depth(CmdDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // Segment buffer: written by the front, read by the back end.
  fss_ram #(.Width(8), .Depth(ExtMax)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Back: execute commands and drive the output register.
  fss_back #(.ExtMax(ExtMax)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_valid_i (!fifo_empty),
    .pop_o       (pop),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .rd_done_o   (rd_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/fss_checker.sv
// Port-level checker for the filename sanitizer, bound to the top level.
`include "filename_sanitizer_stream_unit_defines.svh"

module fss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input fss_pkg::fss_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fss_pkg::fss_out_t out_data_o
);

  logic in_wait, out_wait, marker, marker_ok;

  assign in_wait   = in_valid_i && !in_ready_o;
  assign out_wait  = out_valid_o && !out_ready_i;
  assign marker    = out_valid_o && !out_data_o.char_valid;
  assign marker_ok = out_data_o.name_end && out_data_o.run_end &&
                     (out_data_o.char_out == 8'h00);

  // A stalled result stays put.
  `FSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data_o))

  // A waiting input transfer stays put.
  `FSS_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(in_data_i))

  // The end of a name is also the end of a byte's results.
  `FSS_ASSERT_IMP(a_name_run, clk_i, rst_ni, out_valid_o && out_data_o.name_end, out_data_o.run_end)

  // An empty marker only closes a name and carries a zero byte.
  `FSS_ASSERT_IMP(a_marker, clk_i, rst_ni, marker, marker_ok)

endmodule

bind filename_sanitizer_stream_unit fss_checker u_fss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
